// ===== rtl/shso_pkg.sv =====
package shso_pkg;

    // fixed field widths
    localparam int RATE_W      = 24;
    localparam int AMP_W       = 16;
    localparam int PHASE_W     = 24;
    localparam int COUNT_W     = 5;
    localparam int STEP_W      = 24;
    localparam int ACC_W       = 32;
    localparam int ANGLE_W     = 19;
    localparam int SINE_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // default parameter values
    localparam int MAX_HARMONICS     = 16;
    localparam int SINE_TABLE_DEPTH  = 1024;

    // register reset values
    localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd65536;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

    // 0.01 as 655 / 2^16
    localparam int EASE_Q16 = 655;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam int ANGLE_MAX = 262143;
    localparam int ANGLE_MIN = -262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RATE      = 2'd0,
        CFG_TARGET_AMPLITUDE = 2'd1,
        CFG_TARGET_PHASE     = 2'd2,
        CFG_HARMONIC_COUNT   = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        EASE_RATE   = 2'd0,
        EASE_AMP    = 2'd1,
        EASE_OFFSET = 2'd2
    } ease_sel_t;

    typedef struct packed {
        logic      in_take;
        logic      load_acc;
        logic      ease_en;
        ease_sel_t ease_sel;
        logic      adv_mul;
        logic      adv_add;
        logic      emit_init;
        logic      issue;
        logic      finish;
    } shso_cmd_t;

    typedef struct packed {
        logic h_zero;
        logic issue_last;
        logic pipe_busy;
    } shso_status_t;

    // sine of one turn fraction t (Q0.32), Q1.14, quarter-wave folded taylor series
    function automatic logic [SINE_W-1:0] sine_q14(input logic [31:0] t_in);
        logic [31:0] t;
        logic        neg;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] s;
        t   = t_in;
        neg = 1'b0;
        if (t >= 32'h8000_0000) begin
            neg = 1'b1;
            t   = t - 32'h8000_0000;
        end
        if (t > 32'h4000_0000) begin
            t = 32'h8000_0000 - t;
        end
        x  = (64'(t) * TWO_PI_Q30) >> 32;
        x2 = (x * x) >> 30;
        r  = (64'd1 << 30) - (x2 / 64'd110);
        r  = (64'd1 << 30) - (((x2 * r) >> 30) / 64'd72);
        r  = (64'd1 << 30) - (((x2 * r) >> 30) / 64'd42);
        r  = (64'd1 << 30) - (((x2 * r) >> 30) / 64'd20);
        r  = (64'd1 << 30) - (((x2 * r) >> 30) / 64'd6);
        s  = (x * r) >> 30;
        s  = (s + 64'd32768) >> 16;
        if (s > 64'd16384) begin
            s = 64'd16384;
        end
        return neg ? (SINE_W'(0) - SINE_W'(s)) : SINE_W'(s);
    endfunction

endpackage

// ===== rtl/shso_sine_rom.sv =====
module shso_sine_rom import shso_pkg::*; #(
    parameter int Depth = SINE_TABLE_DEPTH
) (
    input  logic                       aclk,
    input  logic [$clog2(Depth)-1:0]   addr,
    output logic signed [SINE_W-1:0]   data
);

    typedef logic signed [SINE_W-1:0] rom_t [Depth];

    function automatic rom_t build_rom();
        rom_t        tab;
        logic [63:0] t;
        for (int k = 0; k < Depth; k++) begin
            t      = (64'(k) << 32) / 64'(Depth);
            tab[k] = sine_q14(t[31:0]);
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic signed [SINE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/shso_ctrl.sv =====
module shso_ctrl import shso_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_command,
    output logic         m_valid,
    input  logic         m_ready,
    input  shso_status_t status,
    output shso_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EASE_RATE,
        ST_EASE_AMP,
        ST_EASE_OFF,
        ST_ADV_MUL,
        ST_ADV_ADD,
        ST_SETUP,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.ease_sel = EASE_RATE;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_take = s_valid;
                if (s_valid) begin
                    if (command_t'(s_command) == CMD_LOAD) begin
                        cmd.load_acc = 1'b1;
                        state_next   = ST_SETUP;
                    end else begin
                        state_next = ST_EASE_RATE;
                    end
                end
            end
            ST_EASE_RATE: begin
                cmd.ease_en  = 1'b1;
                cmd.ease_sel = EASE_RATE;
                state_next   = ST_EASE_AMP;
            end
            ST_EASE_AMP: begin
                cmd.ease_en  = 1'b1;
                cmd.ease_sel = EASE_AMP;
                state_next   = ST_EASE_OFF;
            end
            ST_EASE_OFF: begin
                cmd.ease_en  = 1'b1;
                cmd.ease_sel = EASE_OFFSET;
                state_next   = ST_ADV_MUL;
            end
            ST_ADV_MUL: begin
                cmd.adv_mul = 1'b1;
                state_next  = ST_ADV_ADD;
            end
            ST_ADV_ADD: begin
                cmd.adv_add = 1'b1;
                state_next  = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.emit_init = 1'b1;
                state_next    = status.h_zero ? ST_FINISH : ST_ISSUE;
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (status.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register can take the result
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/shso_datapath.sv =====
module shso_datapath import shso_pkg::*; #(
    parameter int MaxHarmonics   = MAX_HARMONICS,
    parameter int SineTableDepth = SINE_TABLE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic [STEP_W-1:0]         s_time_step,
    input  logic [ACC_W-1:0]          s_new_phase,
    input  shso_cmd_t                 cmd,
    output shso_status_t              status,
    output logic signed [ANGLE_W-1:0] m_angle,
    output logic                      m_saturated
);

    localparam int NW    = $clog2(MaxHarmonics + 1);
    localparam int AW    = $clog2(SineTableDepth);
    localparam int DPW   = $clog2(SineTableDepth + 1);
    localparam int IPW   = ACC_W + DPW;
    localparam int SUM_W = 31 + $clog2(MaxHarmonics + 1);
    localparam int EW    = 26;
    localparam int EPW   = 37;

    // configuration and smoothed state
    logic [RATE_W-1:0]         target_rate_reg;
    logic signed [AMP_W-1:0]   target_amp_reg;
    logic signed [PHASE_W-1:0] target_phase_reg;
    logic [COUNT_W-1:0]        harm_count_reg;
    logic [RATE_W-1:0]         cur_rate_reg;
    logic signed [AMP_W-1:0]   cur_amp_reg;
    logic signed [PHASE_W-1:0] cur_off_reg;
    logic [ACC_W-1:0]          acc_reg;

    logic [STEP_W-1:0]         dt_reg;
    logic [RATE_W+STEP_W-1:0]  adv_prod_reg;

    // easing of one value per cycle
    logic signed [EW-1:0]  ease_cur;
    logic signed [EW-1:0]  ease_tgt;
    logic signed [EW-1:0]  ease_diff;
    logic signed [EPW-1:0] ease_prod;
    logic signed [EPW-1:0] ease_step;
    logic signed [EW-1:0]  ease_next;

    always_comb begin
        ease_cur = '0;
        ease_tgt = '0;
        unique case (cmd.ease_sel)
            EASE_RATE: begin
                ease_cur = $signed({2'b00, cur_rate_reg});
                ease_tgt = $signed({2'b00, target_rate_reg});
            end
            EASE_AMP: begin
                ease_cur = EW'(cur_amp_reg);
                ease_tgt = EW'(target_amp_reg);
            end
            EASE_OFFSET: begin
                ease_cur = EW'(cur_off_reg);
                ease_tgt = EW'(target_phase_reg);
            end
            default: ;
        endcase
        ease_diff = ease_tgt - ease_cur;
        ease_prod = EPW'(ease_diff) * $signed(EPW'(EASE_Q16));
        ease_step = (ease_prod + $signed(EPW'(32768))) >>> 16;
        ease_next = ease_cur + ease_step[EW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_rate_reg  <= RATE_RESET;
            target_amp_reg   <= '0;
            target_phase_reg <= '0;
            harm_count_reg   <= COUNT_RESET;
            cur_rate_reg     <= RATE_RESET;
            cur_amp_reg      <= '0;
            cur_off_reg      <= '0;
            acc_reg          <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_TARGET_RATE:      target_rate_reg  <= cfg_data[RATE_W-1:0];
                    CFG_TARGET_AMPLITUDE: target_amp_reg   <= cfg_data[AMP_W-1:0];
                    CFG_TARGET_PHASE:     target_phase_reg <= cfg_data[PHASE_W-1:0];
                    CFG_HARMONIC_COUNT:   harm_count_reg   <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.ease_en) begin
                unique case (cmd.ease_sel)
                    EASE_RATE:   cur_rate_reg <= ease_next[RATE_W-1:0];
                    EASE_AMP:    cur_amp_reg  <= ease_next[AMP_W-1:0];
                    EASE_OFFSET: cur_off_reg  <= ease_next[PHASE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load_acc) begin
                acc_reg <= s_new_phase;
            end else if (cmd.adv_add) begin
                // Q8.40 product down to Q0.32, wrapping
                acc_reg <= acc_reg + adv_prod_reg[ACC_W+7:8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_take) begin
            dt_reg <= s_time_step;
        end
        if (cmd.adv_mul) begin
            adv_prod_reg <= (RATE_W+STEP_W)'(cur_rate_reg) * (RATE_W+STEP_W)'(dt_reg);
        end
    end

    // harmonic issue
    logic [NW-1:0]    h_eff;
    logic [NW-1:0]    n_reg;
    logic [ACC_W-1:0] nacc_reg;

    assign h_eff = (32'(harm_count_reg) > MaxHarmonics) ? NW'(MaxHarmonics)
                                                       : NW'(harm_count_reg);

    // term pipeline
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic [ACC_W-1:0]         arg;
    logic [IPW-1:0]           idx_prod;
    logic [AW-1:0]            p1_idx_reg;
    logic [NW-1:0]            p1_n_reg;
    logic [NW-1:0]            p2_n_reg;
    logic signed [SINE_W-1:0] sine_q;
    logic signed [31:0]       p3_prod_reg;
    logic [NW-1:0]            p3_n_reg;
    logic [31:0]              p3_mag;
    logic                     p3_neg;
    logic [29:0]              p4_x_reg;
    logic                     p4_neg_reg;
    logic [NW-1:0]            p4_n_reg;
    logic [30:0]              recip;
    logic [60:0]              q_full;
    logic [30:0]              p5_q0_reg;
    logic [29:0]              p5_x_reg;
    logic                     p5_neg_reg;
    logic [NW-1:0]            p5_n_reg;
    logic [30+NW:0]           q_check;
    logic [30:0]              q_fix;
    logic signed [SUM_W-1:0]  term;
    logic signed [SUM_W-1:0]  sum_reg;

    // ceil(2^30 / n) for each harmonic number
    logic [30:0] recip_tab [2**NW];

    for (genvar g = 0; g < 2**NW; g++) begin : g_recip
        localparam longint RcpVal = (g == 0) ? 0
                                             : ((64'd1 << 30) + g - 1) / ((g == 0) ? 1 : g);
        assign recip_tab[g] = 31'(RcpVal);
    end

    assign arg      = nacc_reg + {cur_off_reg[15:0], 16'h0000};
    assign idx_prod = IPW'(arg) * IPW'(SineTableDepth);

    shso_sine_rom #(
        .Depth (SineTableDepth)
    ) u_sine_rom (
        .aclk (aclk),
        .addr (p1_idx_reg),
        .data (sine_q)
    );

    // floor division of negatives via ceil of the magnitude
    assign p3_neg = p3_prod_reg[31];
    assign p3_mag = p3_neg ? (32'd0 - 32'(p3_prod_reg)) : 32'(p3_prod_reg);

    assign recip  = recip_tab[p4_n_reg];
    assign q_full = 61'(p4_x_reg) * 61'(recip);

    // reciprocal estimate is at most one too high
    assign q_check = (31+NW)'(p5_q0_reg) * (31+NW)'(p5_n_reg);
    assign q_fix   = (q_check > (31+NW)'(p5_x_reg)) ? (p5_q0_reg - 31'd1) : p5_q0_reg;
    assign term    = p5_neg_reg ? (SUM_W'(0) - SUM_W'(q_fix[29:0])) : SUM_W'(q_fix[29:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            n_reg  <= '0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (cmd.emit_init) begin
                n_reg <= NW'(1);
            end else if (cmd.issue) begin
                n_reg <= n_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_init) begin
            nacc_reg <= acc_reg;
        end else if (cmd.issue) begin
            nacc_reg <= nacc_reg + acc_reg;
        end
        p1_idx_reg  <= idx_prod[ACC_W +: AW];
        p1_n_reg    <= n_reg;
        p2_n_reg    <= p1_n_reg;
        p3_prod_reg <= 32'(cur_amp_reg) * 32'(sine_q);
        p3_n_reg    <= p2_n_reg;
        p4_x_reg    <= p3_mag[29:0] + (p3_neg ? 30'(p3_n_reg - NW'(1)) : 30'd0);
        p4_neg_reg  <= p3_neg;
        p4_n_reg    <= p3_n_reg;
        p5_q0_reg   <= q_full[60:30];
        p5_x_reg    <= p4_x_reg;
        p5_neg_reg  <= p4_neg_reg;
        p5_n_reg    <= p4_n_reg;
        if (cmd.emit_init) begin
            sum_reg <= '0;
        end else if (v5_reg) begin
            sum_reg <= sum_reg + term;
        end
    end

    // rounding off the Q14 fraction and clipping
    logic signed [SUM_W-1:0]   rnd;
    logic                      over;
    logic                      under;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                      sat_reg;

    assign rnd   = (sum_reg + $signed(SUM_W'(8192))) >>> 14;
    assign over  = rnd > $signed(SUM_W'(ANGLE_MAX));
    assign under = rnd < $signed(SUM_W'(ANGLE_MIN));

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (over) begin
                angle_reg <= ANGLE_W'(ANGLE_MAX);
            end else if (under) begin
                angle_reg <= ANGLE_W'(ANGLE_MIN);
            end else begin
                angle_reg <= rnd[ANGLE_W-1:0];
            end
            sat_reg <= over || under;
        end
    end

    assign m_angle     = angle_reg;
    assign m_saturated = sat_reg;

    assign status.h_zero     = (h_eff == '0);
    assign status.issue_last = (n_reg == h_eff);
    assign status.pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;

endmodule

// ===== rtl/smoothed_harmonic_sawtooth_oscillator_unit.sv =====
// a tick eases rate, amplitude and offset, advances the phase and then sums h harmonics;
// a load sets the phase and sums them, where h is the harmonic count clamped to the maximum;
// with h zero the sum is skipped
// requests are taken one at a time, each once the previous result is in the output register;
// one harmonic enters the term pipeline per cycle, the rest is easing and drain
// reset: synchronous, active low; targets and smoothed state return to defaults
module smoothed_harmonic_sawtooth_oscillator_unit import shso_pkg::*; #(
    parameter int MaxHarmonics   = MAX_HARMONICS,
    parameter int SineTableDepth = SINE_TABLE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic [STEP_W-1:0]         s_time_step,
    input  logic [ACC_W-1:0]          s_new_phase,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ANGLE_W-1:0] m_angle,
    output logic                      m_saturated
);

    shso_cmd_t    cmd;
    shso_status_t status;

    assign cfg_ready = 1'b1;

    shso_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    shso_datapath #(
        .MaxHarmonics   (MaxHarmonics),
        .SineTableDepth (SineTableDepth)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_time_step (s_time_step),
        .s_new_phase (s_new_phase),
        .cmd         (cmd),
        .status      (status),
        .m_angle     (m_angle),
        .m_saturated (m_saturated)
    );

endmodule

// ===== tb/sv/tb_smoothed_harmonic_sawtooth_oscillator_unit.sv =====
`timescale 1ns / 100ps

module tb_smoothed_harmonic_sawtooth_oscillator_unit;
    import shso_pkg::*;

    localparam int DRAIN_CYCLES = MAX_HARMONICS + 24;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_REQUESTS = 104;
    localparam int IDLE_PERCENT = 34;
    localparam longint EASE_STEP_Q16 = 655;
    localparam longint unsigned TURN_RAD_Q30 = 64'd6746518852;

    typedef struct packed {
        bit          is_write;
        cfg_reg_t    sel;
        bit [23:0]   wdata;
        command_t    cmd;
        bit [23:0]   step;
        bit [31:0]   phase;
        bit          typed;
        bit [18:0]   angle;
        bit          sat;
    } stim_row_t;

    typedef struct packed {
        bit [18:0] angle;
        bit        sat;
    } angle_result_t;

    localparam stim_row_t DIRECTED_ROWS [25] = '{
        // amplitude still zero after reset
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_TICK, 24'h000000, 32'h0, 1'b1, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_TICK, 24'hFFFFFF, 32'h0, 1'b1, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_LOAD, 24'h0, 32'hFFFFFFFF, 1'b1, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_LOAD, 24'h0, 32'h00000000, 1'b1, 19'd0, 1'b0},
        // no harmonics summed gives zero whatever the amplitude
        '{1'b1, CFG_HARMONIC_COUNT, 24'h000000, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b1, CFG_TARGET_AMPLITUDE, 24'h007FFF, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_TICK, 24'hFFFFFF, 32'h0, 1'b1, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_LOAD, 24'h0, 32'h80000000, 1'b1, 19'd0, 1'b0},
        // count above the maximum is clamped
        '{1'b1, CFG_HARMONIC_COUNT, 24'h00001F, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b1, CFG_TARGET_RATE, 24'hFFFFFF, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b1, CFG_TARGET_PHASE, 24'h7FFFFF, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_TICK, 24'hFFFFFF, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_TICK, 24'h800000, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_LOAD, 24'h0, 32'h40000000, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_LOAD, 24'h0, 32'hFFFFFFFF, 1'b0, 19'd0, 1'b0},
        '{1'b1, CFG_TARGET_AMPLITUDE, 24'hFF8000, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b1, CFG_TARGET_PHASE, 24'h800000, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b1, CFG_TARGET_RATE, 24'h000000, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b1, CFG_HARMONIC_COUNT, 24'h000010, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_TICK, 24'h000001, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_TICK, 24'hFFFFFF, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_LOAD, 24'h0, 32'h12345678, 1'b0, 19'd0, 1'b0},
        '{1'b1, CFG_HARMONIC_COUNT, 24'h000001, CMD_TICK, 24'h0, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_TICK, 24'h000100, 32'h0, 1'b0, 19'd0, 1'b0},
        '{1'b0, CFG_TARGET_RATE, 24'h0, CMD_LOAD, 24'h0, 32'hC0000000, 1'b0, 19'd0, 1'b0}
    };

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_command = 1'b0;
    logic [STEP_W-1:0]         s_time_step = '0;
    logic [ACC_W-1:0]          s_new_phase = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [ANGLE_W-1:0] m_angle;
    logic                      m_saturated;

    // typed-in expectation travelling with the request on the bus
    logic        drv_typed = 1'b0;
    logic [18:0] drv_angle = '0;
    logic        drv_sat = 1'b0;

    bit quiet = 1'b0;

    // oscillator copy: targets, smoothed values and accumulator
    bit [23:0]        rate_goal = RATE_RESET;
    bit signed [15:0] amp_goal = '0;
    bit signed [23:0] ofs_goal = '0;
    bit [4:0]         harm_cfg = COUNT_RESET;
    bit [23:0]        rate_now = RATE_RESET;
    bit signed [15:0] amp_now = '0;
    bit signed [23:0] ofs_now = '0;
    bit [31:0]        acc_now = '0;
    int               sine_lut [SINE_TABLE_DEPTH];

    angle_result_t angle_due_q [$];
    angle_result_t predicted;
    angle_result_t oldest;

    int errors = 0;
    int n_ticks = 0;
    int n_loads = 0;
    int n_writes = 0;
    int n_results = 0;
    int n_clipped = 0;
    int stall_cycles = 0;

    smoothed_harmonic_sawtooth_oscillator_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_time_step (s_time_step),
        .s_new_phase (s_new_phase),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_angle     (m_angle),
        .m_saturated (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // quarter-wave folded series, one entry per table step over one turn
    function automatic void fill_sine_lut();
        longint unsigned t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        longint unsigned s;
        bit              neg;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            t = (64'(k) << 32) / SINE_TABLE_DEPTH;
            neg = 1'b0;
            if (t >= 64'h8000_0000) begin
                neg = 1'b1;
                t = t - 64'h8000_0000;
            end
            if (t > 64'h4000_0000) begin
                t = 64'h8000_0000 - t;
            end
            x = (t * TURN_RAD_Q30) >> 32;
            x2 = (x * x) >> 30;
            r = (64'd1 << 30) - (x2 / 110);
            r = (64'd1 << 30) - (((x2 * r) >> 30) / 72);
            r = (64'd1 << 30) - (((x2 * r) >> 30) / 42);
            r = (64'd1 << 30) - (((x2 * r) >> 30) / 20);
            r = (64'd1 << 30) - (((x2 * r) >> 30) / 6);
            s = (x * r) >> 30;
            s = (s + 64'd32768) >> 16;
            if (s > 64'd16384) begin
                s = 64'd16384;
            end
            sine_lut[k] = neg ? -int'(s) : int'(s);
        end
    endfunction

    // one percent of the gap, rounded to nearest
    function automatic longint eased(longint cur, longint goal);
        return cur + (((goal - cur) * EASE_STEP_Q16 + 32768) >>> 16);
    endfunction

    function automatic angle_result_t predict_angle(command_t cmd, bit [23:0] step,
                                                    bit [31:0] phase);
        longint        total;
        longint        prod;
        longint        quot;
        longint        rounded;
        bit [31:0]     arg;
        bit [31:0]     off;
        int            h;
        int            idx;
        angle_result_t res;
        if (cmd == CMD_TICK) begin
            rate_now = 24'(eased(rate_now, rate_goal));
            amp_now = 16'(eased(amp_now, amp_goal));
            ofs_now = 24'(eased(ofs_now, ofs_goal));
            acc_now = acc_now + 32'((64'(rate_now) * 64'(step)) >> 8);
        end else begin
            acc_now = phase;
        end
        h = (harm_cfg > MAX_HARMONICS) ? MAX_HARMONICS : int'(harm_cfg);
        off = {ofs_now[15:0], 16'h0000};
        total = 0;
        for (int n = 1; n <= h; n++) begin
            arg = acc_now * 32'(n) + off;
            idx = int'((64'(arg) * SINE_TABLE_DEPTH) >> 32);
            prod = longint'(amp_now) * longint'(sine_lut[idx]);
            quot = prod / n;
            if (prod % n != 0 && prod < 0) begin
                quot = quot - 1;
            end
            total = total + quot;
        end
        rounded = (total + 8192) >>> 14;
        res.sat = 1'b0;
        if (rounded > ANGLE_MAX) begin
            rounded = ANGLE_MAX;
            res.sat = 1'b1;
        end
        if (rounded < ANGLE_MIN) begin
            rounded = ANGLE_MIN;
            res.sat = 1'b1;
        end
        res.angle = 19'(rounded);
        return res;
    endfunction

    task automatic send_req(command_t cmd, bit [23:0] step, bit [31:0] phase,
                            bit typed, bit [18:0] angle, bit sat);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_time_step <= step;
        s_new_phase <= phase;
        drv_typed <= typed;
        drv_angle <= angle;
        drv_sat <= sat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t sel, bit [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold requests until every answer is back and the pipeline has drained
    task automatic settle_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (angle_due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                n_writes++;
                case (cfg_reg_t'(cfg_index))
                    CFG_TARGET_RATE:      rate_goal = cfg_data;
                    CFG_TARGET_AMPLITUDE: amp_goal = cfg_data[15:0];
                    CFG_TARGET_PHASE:     ofs_goal = cfg_data;
                    CFG_HARMONIC_COUNT:   harm_cfg = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predicted = predict_angle(command_t'(s_command), s_time_step, s_new_phase);
                if (drv_typed) begin
                    predicted.angle = drv_angle;
                    predicted.sat = drv_sat;
                end
                angle_due_q.push_back(predicted);
                if (command_t'(s_command) == CMD_TICK) begin
                    n_ticks++;
                end else begin
                    n_loads++;
                end
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (m_saturated === 1'b1) begin
                    n_clipped++;
                end
                if (angle_due_q.size() == 0) begin
                    $display("%0t: unrequested result, angle %0d saturated %0b",
                             $time, m_angle, m_saturated);
                    errors++;
                end else begin
                    oldest = angle_due_q.pop_front();
                    if (m_angle !== oldest.angle) begin
                        $display("%0t: angle expected %0d got %0d", $time,
                                 $signed(oldest.angle), m_angle);
                        errors++;
                    end
                    if (m_saturated !== oldest.sat) begin
                        $display("%0t: saturated expected %0b got %0b", $time,
                                 oldest.sat, m_saturated);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, angle_due_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int        first;
        bit [23:0] wval;
        bit [23:0] step;
        bit [31:0] phase;
        fill_sine_lut();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            if (DIRECTED_ROWS[i].is_write) begin
                settle_idle();
                write_reg(DIRECTED_ROWS[i].sel, DIRECTED_ROWS[i].wdata);
            end else begin
                send_req(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].step, DIRECTED_ROWS[i].phase,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].angle,
                         DIRECTED_ROWS[i].sat);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle_idle();
            quiet = (p == 5 || p == 6);
            first = $urandom_range(3);
            for (int j = 0; j < 4; j++) begin
                wval = 24'($urandom);
                case (cfg_reg_t'((first + j) % 4))
                    CFG_TARGET_RATE: begin
                        case ($urandom_range(3))
                            0: wval = 24'h000000;
                            1: wval = 24'hFFFFFF;
                            default: ;
                        endcase
                    end
                    CFG_TARGET_AMPLITUDE: begin
                        case ($urandom_range(3))
                            0: wval[15:0] = 16'h8000;
                            1: wval[15:0] = 16'h7FFF;
                            default: ;
                        endcase
                    end
                    CFG_TARGET_PHASE: begin
                        case ($urandom_range(3))
                            0: wval = 24'h800000;
                            1: wval = 24'h7FFFFF;
                            default: ;
                        endcase
                    end
                    default: begin
                        case ($urandom_range(4))
                            0: wval[4:0] = 5'd0;
                            1: wval[4:0] = 5'd16;
                            2: wval[4:0] = 5'd31;
                            default: ;
                        endcase
                    end
                endcase
                write_reg(cfg_reg_t'((first + j) % 4), wval);
            end
            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                if ($urandom_range(99) < 70) begin
                    case ($urandom_range(3))
                        0: step = 24'($urandom_range(255));
                        1: step = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                        default: step = 24'($urandom);
                    endcase
                    send_req(CMD_TICK, step, $urandom, 1'b0, '0, 1'b0);
                end else begin
                    phase = $urandom;
                    if ($urandom_range(9) == 0) begin
                        phase = $urandom_range(1) ? 32'hFFFFFFFF : 32'h00000000;
                    end
                    send_req(CMD_LOAD, 24'($urandom), phase, 1'b0, '0, 1'b0);
                end
            end
        end

        settle_idle();
        $display("covered %0d ticks and %0d loads across %0d register writes",
                 n_ticks, n_loads, n_writes);
        $display("%0d results checked, %0d clipped, %0d mismatches",
                 n_results, n_clipped, errors);
        if (errors == 0 && angle_due_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/shso_pkg.sv
rtl/shso_sine_rom.sv
rtl/shso_ctrl.sv
rtl/shso_datapath.sv
rtl/smoothed_harmonic_sawtooth_oscillator_unit.sv
tb/sv/tb_smoothed_harmonic_sawtooth_oscillator_unit.sv
